// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Assert an implication whose consequent holds in the cycle after the antecedent, outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: rtl/aesctr_pkg.sv
// Package: AES constants, S-box and shared types for the CTR keystream core
package aesctr_pkg;

   localparam int NUM_ROUNDS  = 14;
   localparam int SCHED_WORDS = 60;
   localparam int KEY_WORDS   = 8;
   localparam int RK_AW       = 6;
   localparam int CSR_AW      = 3;

   localparam logic [CSR_AW-1:0] CSR_KEY0  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_KEY1  = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_KEY2  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_KEY3  = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_NONCE = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEXP,
      ST_RKRD,
      ST_ROUND,
      ST_OUT
   } state_type;

   // S-box lookup
   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // One column of MixColumns, row 0 in the top byte
   function automatic logic [31:0] mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      b0 = xtime(a0); b1 = xtime(a1); b2 = xtime(a2); b3 = xtime(a3);
      return {b0 ^ a1 ^ b1 ^ a2 ^ a3, a0 ^ b1 ^ a2 ^ b2 ^ a3,
              a0 ^ a1 ^ b2 ^ a3 ^ b3, a0 ^ b0 ^ a1 ^ a2 ^ b3};
   endfunction

endpackage

// File: rtl/aesctr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module aesctr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: rtl/aes256_ctr_keystream_xor_core.sv
// Top level: AES-256 CTR keystream XOR core, one byte per item
// An item whose byte comes from the held keystream block is accepted in idle,
// and its result is then offered from the output state until it is taken.
// The first byte of every 16-byte block also runs the counter through AES:
// one column of one round per cycle on a shared S-box/MixColumns column unit
// fed by the round-key RAM. A state that primes the RAM read comes before the
// 15 round-key additions; the result is then offered from the output state,
// and the core goes back to idle once it is taken. A key write starts a key
// expansion of all 60 schedule words, one round-key word per cycle, during
// which no item is accepted. No item is accepted in a cycle that carries a register write.
module aes256_ctr_keystream_xor_core import aesctr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_index,
   input  logic [63:0]         csr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_message_start,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte
);
   state_type state_ff, state_in;
   logic [255:0] key_ff, key_in;
   logic [63:0]  nonce_ff, nonce_in;
   logic [63:0]  blk_ff, blk_in;
   logic [3:0]   off_ff, off_in;
   logic [127:0] ks_ff, ks_in;
   logic [127:0] st_ff, st_in;
   logic [7:0]   data_ff, data_in;
   logic [7:0]   out_ff, out_in;
   logic [RK_AW-1:0] widx_ff, widx_in;   // key expansion word / round-key read address
   logic [255:0] win_ff, win_in;         // sliding window of last 8 schedule words
   logic [3:0]   rnd_ff, rnd_in;
   logic [1:0]   col_ff, col_in;

   logic         rk_we;
   logic [RK_AW-1:0] rk_waddr, rk_raddr;
   logic [31:0]  rk_wdata, rk_rdata;

   aesctr_ram #(.WIDTH(32), .DEPTH(64)) u_rk (
      .clock, .wr_en(rk_we), .wr_addr(rk_waddr), .wr_data(rk_wdata),
      .rd_addr(rk_raddr), .rd_data(rk_rdata)
   );

   // schedule word computation from the window
   logic [31:0] t_word, new_word;
   logic [7:0]  rc;
   always_comb begin
      t_word = win_ff[31:0];
      case (widx_ff[5:3])
         3'd1: rc = 8'h01;
         3'd2: rc = 8'h02;
         3'd3: rc = 8'h04;
         3'd4: rc = 8'h08;
         3'd5: rc = 8'h10;
         3'd6: rc = 8'h20;
         3'd7: rc = 8'h40;
         default: rc = 8'h00;
      endcase
      if (widx_ff[2:0] == 3'd0) begin
         t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {rc, 24'h0};
      end else if (widx_ff[2:0] == 3'd4) begin
         t_word = sub_word(t_word);
      end
      new_word = win_ff[255:224] ^ t_word;
   end

   // round unit: column c after SubBytes/ShiftRows, MixColumns (not last round), key add
   logic [7:0]  sb [4];
   logic [31:0] col_mix, col_out;
   logic        last_rnd;
   assign last_rnd = (rnd_ff == 4'(NUM_ROUNDS));
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sb[r] = sbox(st_ff[127 - 32*((int'(col_ff) + r) & 3) - 8*r -: 8]);
      end
      col_mix = last_rnd ? {sb[0], sb[1], sb[2], sb[3]}
                         : mix_col({sb[0], sb[1], sb[2], sb[3]});
      col_out = col_mix ^ rk_rdata;
   end

   logic req_acc, rsp_acc;
   logic [3:0] off_eff;
   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && rsp_stall == 1'b0;
   assign off_eff = req_message_start ? 4'd0 : off_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_we && csr_index <= CSR_KEY3) state_in = ST_KEXP;
            else if (req_acc) state_in = (off_eff == 4'd0) ? ST_RKRD : ST_OUT;
         end
         ST_KEXP: if (widx_ff == 6'(SCHED_WORDS - 1)) state_in = ST_IDLE;
         ST_RKRD: state_in = ST_ROUND;
         ST_ROUND: if (last_rnd && col_ff == 2'd3) state_in = ST_OUT;
         ST_OUT:  if (rsp_acc) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      key_in = key_ff; nonce_in = nonce_ff; blk_in = blk_ff; off_in = off_ff;
      ks_in = ks_ff; st_in = st_ff; data_in = data_ff; out_in = out_ff;
      widx_in = widx_ff; win_in = win_ff; rnd_in = rnd_ff; col_in = col_ff;
      rk_we = 1'b0; rk_waddr = widx_ff; rk_wdata = new_word; rk_raddr = widx_ff;
      // hold off items while busy and in a register write cycle
      req_stall = (state_ff != ST_IDLE) || csr_we;
      rsp_valid = (state_ff == ST_OUT);
      case (state_ff)
         ST_IDLE: begin
            // take writes, the key copy goes into the first 8 words
            if (csr_we) begin
               case (csr_index)
                  CSR_KEY0: key_in[255:192] = csr_data;
                  CSR_KEY1: key_in[191:128] = csr_data;
                  CSR_KEY2: key_in[127:64]  = csr_data;
                  CSR_KEY3: key_in[63:0]    = csr_data;
                  CSR_NONCE: nonce_in = csr_data;
                  default: ;
               endcase
               widx_in = 6'd0;
               win_in = key_in;
            end else if (req_acc) begin
               data_in = req_data_byte;
               off_in = off_eff + 4'd1;
               widx_in = 6'd0;
               rnd_in = 4'd0;
               col_in = 2'd0;
               if (off_eff == 4'd0) begin
                  // build counter block, round 0 key added as words arrive
                  st_in = {nonce_ff, req_message_start ? 64'd0 : blk_ff};
                  blk_in = (req_message_start ? 64'd0 : blk_ff) + 64'd1;
               end else begin
                  out_in = req_data_byte ^ ks_ff[127 - 8*off_eff -: 8];
               end
            end
         end
         ST_KEXP: begin
            // write one schedule word per cycle
            rk_we = 1'b1;
            if (widx_ff < 6'(KEY_WORDS)) begin
               rk_wdata = win_ff[255 - 32*widx_ff -: 32];
               if (widx_ff == 6'(KEY_WORDS - 1)) win_in = win_ff;
            end else begin
               win_in = {win_ff[223:0], new_word};
            end
            widx_in = widx_ff + 6'd1;
         end
         ST_RKRD: begin
            // prime the read of round key word 0
            rk_raddr = 6'd0;
            widx_in = 6'd1;
         end
         ST_ROUND: begin
            rk_raddr = widx_ff;
            widx_in = widx_ff + 6'd1;
            col_in = col_ff + 2'd1;
            if (rnd_ff == 4'd0) begin
               st_in[127 - 32*col_ff -: 32] = st_ff[127 - 32*col_ff -: 32] ^ rk_rdata;
            end else begin
               // columns written to a shadow: keep the old state until round ends
               ks_in[127 - 32*col_ff -: 32] = col_out;
               if (col_ff == 2'd3) st_in = {ks_in[127:32], col_out};
            end
            if (col_ff == 2'd3) rnd_in = rnd_ff + 4'd1;
            if (last_rnd && col_ff == 2'd3) begin
               out_in = data_ff ^ ks_in[127:120];
            end
         end
         ST_OUT: ;
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         key_ff <= '0; nonce_ff <= '0; blk_ff <= '0; off_ff <= '0; ks_ff <= '0;
      end else begin
         state_ff <= state_in;
         key_ff <= key_in; nonce_ff <= nonce_in; blk_ff <= blk_in;
         off_ff <= off_in; ks_ff <= ks_in;
      end
      st_ff <= st_in; data_ff <= data_in; out_ff <= out_in;
      widx_ff <= widx_in; win_ff <= win_in; rnd_ff <= rnd_in; col_ff <= col_in;
   end

   assign rsp_out_byte = out_ff;
endmodule

// File: rtl/aesctr_checker.sv
// Port-level checker for the AES-256 CTR core, bound to the top level
`include "assert_macros.svh"
module aesctr_checker import aesctr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              csr_we,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [7:0]        rsp_out_byte
);
   // an accepted item makes the block busy next cycle
   `ASSERT_NEXT(a_busy, clock, reset, req_valid && !req_stall, req_stall)
   // no result is offered while a new item could be taken
   `ASSERT_IMPLY(a_excl, clock, reset, rsp_valid, req_stall)
   // a stalled result holds its byte
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte))
   // a delivered result frees the block
   `ASSERT_NEXT(a_free, clock, reset, rsp_valid && !rsp_stall && !csr_we, !rsp_valid)
endmodule

bind aes256_ctr_keystream_xor_core aesctr_checker u_chk (
   .clock, .reset, .csr_we, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_out_byte
);

// File: test/aes256_ctr_keystream_xor_checker.sv
// Checker: watches the item channels, predicts each output byte and compares
module aes256_ctr_keystream_xor_checker import aesctr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [63:0]       csr_data,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_message_start,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [7:0]        rsp_out_byte,
   output int                mismatches,
   output int                bytes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]  subst [256];
   logic [63:0] key_reg [4];
   logic [63:0] nonce_reg;
   logic [31:0] sched [60];
   logic [63:0] block_no;
   logic [3:0]  offset;
   logic [7:0]  pad [16];
   logic [7:0]  out_bytes_due [$];

   function automatic logic [7:0] dbl(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ a;
         a = dbl(a);
      end
      return p;
   endfunction

   // Build the substitution table from the field inverse and the affine map
   initial begin
      logic [7:0] inv;
      for (int a = 0; a < 256; a++) begin
         inv = 8'h01;
         for (int k = 0; k < 254; k++) inv = gf_mul(inv, a[7:0]);
         if (a == 0) inv = 8'h00;
         subst[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                    ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      end
   end

   function automatic logic [31:0] subst_word(input logic [31:0] w);
      return {subst[w[31:24]], subst[w[23:16]], subst[w[15:8]], subst[w[7:0]]};
   endfunction

   task automatic expand_schedule();
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      for (int i = 0; i < 8; i++)
         sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
      for (int i = 8; i < 60; i++) begin
         t = sched[i-1];
         if (i % 8 == 0) begin
            t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = dbl(rc);
         end else if (i % 8 == 4) begin
            t = subst_word(t);
         end
         sched[i] = sched[i-8] ^ t;
      end
   endtask

   task automatic mix_key(ref logic [7:0] st [16], input int rnd);
      logic [31:0] w;
      for (int c = 0; c < 4; c++) begin
         w = sched[rnd*4 + c];
         for (int r = 0; r < 4; r++) st[4*c + r] ^= w[31 - 8*r -: 8];
      end
   endtask

   // Encrypt the counter block into the pad
   task automatic encrypt_block();
      logic [7:0] st [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
      for (int i = 0; i < 8; i++) begin
         st[i]     = nonce_reg[63 - 8*i -: 8];
         st[8 + i] = block_no[63 - 8*i -: 8];
      end
      mix_key(st, 0);
      for (int rnd = 1; rnd <= 14; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) t[4*c + r] = subst[st[4*((c + r) % 4) + r]];
         st = t;
         if (rnd < 14) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
               b0 = dbl(a0); b1 = dbl(a1); b2 = dbl(a2); b3 = dbl(a3);
               st[4*c]   = b0 ^ a1 ^ b1 ^ a2 ^ a3;
               st[4*c+1] = a0 ^ b1 ^ a2 ^ b2 ^ a3;
               st[4*c+2] = a0 ^ a1 ^ b2 ^ a3 ^ b3;
               st[4*c+3] = a0 ^ b0 ^ a1 ^ a2 ^ b3;
            end
         end
         mix_key(st, rnd);
      end
      pad = st;
   endtask

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_reg[i] = '0;
         for (int i = 0; i < 60; i++) sched[i] = '0;
         for (int i = 0; i < 16; i++) pad[i] = '0;
         nonce_reg = '0;
         block_no = '0;
         offset = '0;
         out_bytes_due.delete();
         mismatches = 0;
         bytes_pending = 0;
      end else begin
         // Track register writes; out-of-range indexes are dropped
         if (csr_we) begin
            case (csr_index)
               CSR_KEY0, CSR_KEY1, CSR_KEY2, CSR_KEY3: begin
                  key_reg[csr_index[1:0]] = csr_data;
                  expand_schedule();
               end
               CSR_NONCE: nonce_reg = csr_data;
               default: ;
            endcase
         end
         // Predict the output byte of each accepted item
         if (req_valid && !req_stall) begin
            if (req_message_start) begin
               block_no = '0;
               offset = '0;
            end
            if (offset == 4'd0) begin
               encrypt_block();
               block_no = block_no + 64'd1;
            end
            out_bytes_due.push_back(req_data_byte ^ pad[offset]);
            offset = offset + 4'd1;
         end
         // Compare each accepted output byte with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (out_bytes_due.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected output byte %02h", rsp_out_byte);
               mismatches++;
            end else begin
               want = out_bytes_due.pop_front();
               if (want !== rsp_out_byte) begin
                  if (mismatches < 10)
                     $display("out_byte mismatch: expected %02h actual %02h",
                              want, rsp_out_byte);
                  mismatches++;
               end
            end
         end
         bytes_pending = out_bytes_due.size();
      end
   end
endmodule

// File: test/aes256_ctr_keystream_xor_core_tb.sv
// Testbench top: drives stimulus into the core and reports the verdict
module aes256_ctr_keystream_xor_core_tb import aesctr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1500000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [63:0]       csr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_data_byte = '0;
   logic              req_message_start = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_out_byte;
   int                mismatches;
   int                bytes_pending;
   int                cycles = 0;
   int                burst_left = 0;
   int                stall_mode = 0;
   int                stall_left = 0;

   aes256_ctr_keystream_xor_core u_top (.*);

   aes256_ctr_keystream_xor_checker u_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver stall pattern: free, random, mostly stalled or rarely stalled
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 60);
         end
         stall_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            2: rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      // Let any key expansion finish
      repeat (70) @(posedge clock);
   endtask

   // Wait until every predicted byte has come out, then let the core go quiet
   task automatic drain();
      if (req_valid) begin
         req_valid <= 1'b0;
         burst_left = 0;
      end
      while (bytes_pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Hand one item over and hold it until accepted, then maybe idle
   task automatic put_byte(input logic [7:0] d, input logic s);
      int gap;
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_message_start <= s;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_message(input int len, input logic marked);
      for (int k = 0; k < len; k++)
         put_byte(8'($urandom_range(0, 255)), marked && (k == 0));
   endtask

   initial begin
      int len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All-zero key and nonce, first message left unmarked
      for (int i = 0; i < 4; i++) write_reg(CSR_AW'(CSR_KEY0 + i), 64'h0);
      write_reg(CSR_NONCE, 64'h0);
      put_byte(8'h00, 1'b0);
      put_byte(8'hff, 1'b0);
      put_byte(8'h55, 1'b0);
      put_byte(8'haa, 1'b1);
      send_message(15, 1'b0);
      drain();

      // All-ones settings mid-message, plus writes to unused indexes
      write_reg(CSR_KEY0, '1);
      write_reg(CSR_KEY1, '1);
      write_reg(CSR_KEY2, '1);
      write_reg(CSR_KEY3, '1);
      write_reg(CSR_NONCE, '1);
      write_reg(3'd5, {$urandom, $urandom});
      write_reg(3'd6, {$urandom, $urandom});
      write_reg(3'd7, '1);
      put_byte(8'hff, 1'b0);
      put_byte(8'h00, 1'b0);
      send_message(3, 1'b1);
      drain();

      // Random phases: new settings, then mostly well-formed messages
      for (int p = 0; p < 12; p++) begin
         for (int r = 0; r < 8; r++) begin
            if ($urandom_range(0, 2) != 0 || p == 0) begin
               case ($urandom_range(0, 3))
                  0: write_reg(r[2:0], 64'h0);
                  1: write_reg(r[2:0], '1);
                  default: write_reg(r[2:0], {$urandom, $urandom});
               endcase
            end
         end
         for (int n = 0; n < 135; n += len) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                              : $urandom_range(1, 40);
            send_message(len, $urandom_range(0, 9) != 0);
         end
         drain();
      end

      if (mismatches == 0 && bytes_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
